### sv/recursive_lock_fifo_handoff_unit_defines.svh
// Assertion macros for the recursive lock handoff unit.
// Used by the port checker; expects clk and rst in scope.
`ifndef RECURSIVE_LOCK_FIFO_HANDOFF_UNIT_DEFINES_SVH
`define RECURSIVE_LOCK_FIFO_HANDOFF_UNIT_DEFINES_SVH

// same-cycle implication
`define RLFH_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rlfh: same-cycle check failed");

// next-cycle implication
`define RLFH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rlfh: next-cycle check failed");

`endif

### sv/rlfh_pkg.sv
// Shared types and constants for the recursive lock handoff unit.
// No dependencies.
`default_nettype none

package rlfh_pkg;

  localparam int DEF_NUM_TASKS = 16;
  localparam int ORDER_W       = 32;
  localparam int LEVEL_W       = 16;
  localparam int TASK_W        = 4;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_NESTING = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYSTEM_TASK = 1'd1;

  localparam logic [LEVEL_W-1:0] MAX_NESTING_RESET = 16'hFFFF;
  localparam logic [TASK_W-1:0]  SYSTEM_TASK_RESET = 4'd0;

  localparam logic CMD_TAKE    = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic [2:0] ST_GRANTED = 3'd0;
  localparam logic [2:0] ST_BUSY    = 3'd1;
  localparam logic [2:0] ST_QUEUED  = 3'd2;
  localparam logic [2:0] ST_HELD    = 3'd3;
  localparam logic [2:0] ST_FREED   = 3'd4;
  localparam logic [2:0] ST_HANDOFF = 3'd5;
  localparam logic [2:0] ST_SYSTEM  = 3'd6;
  localparam logic [2:0] ST_RELERR  = 3'd7;

  typedef struct packed {
    logic              command;
    logic [TASK_W-1:0] task_req;
    logic              may_wait;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [LEVEL_W-1:0] level;
    logic               woken_valid;
    logic [TASK_W-1:0]  woken_task;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic scan_clear;
    logic cmp_en;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic slot_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

### sv/rlfh_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rlfh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### sv/rlfh_ctrl.sv
// Sequencer for the recursive lock handoff unit: accept, execute, waiter scan, commit.
// Depends on rlfh_pkg.
`default_nettype none

module rlfh_ctrl #(
  parameter int NUM_TASKS = rlfh_pkg::DEF_NUM_TASKS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire rlfh_pkg::ctrl_sts_t          sts,
  output rlfh_pkg::ctrl_cmd_t               cmd,
  output logic [$clog2(NUM_TASKS)-1:0]      rd_addr
);
  import rlfh_pkg::*;

  localparam int TW = $clog2(NUM_TASKS);
  localparam int CW = $clog2(NUM_TASKS + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  logic [1:0]    state, state_next;
  logic [CW-1:0] cnt, cnt_next;

  assign in_stall = (state != S_IDLE);
  assign rd_addr  = cnt[TW-1:0];

  always_comb begin
    cmd        = '0;
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.need_scan) begin
          cmd.scan_clear = 1'b1;
          cnt_next       = '0;
          state_next     = S_SCAN;
        end else if (sts.slot_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.cmp_en = (cnt != '0);
        cnt_next   = cnt + CW'(1);
        if (cnt == CW'(NUM_TASKS)) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (sts.slot_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

`default_nettype wire

### sv/rlfh_dp.sv
// Datapath of the recursive lock handoff unit: lock state, waiter marks,
// wait-order RAM, oldest-waiter search and result register. Depends on rlfh_pkg, rlfh_ram.
`default_nettype none

module rlfh_dp #(
  parameter int NUM_TASKS = rlfh_pkg::DEF_NUM_TASKS
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire rlfh_pkg::req_t                      in_data,
  input  wire rlfh_pkg::ctrl_cmd_t                 cmd,
  output rlfh_pkg::ctrl_sts_t                      sts,
  input  wire logic [$clog2(NUM_TASKS)-1:0]        rd_addr,
  input  wire logic                                cfg_write,
  input  wire logic [rlfh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [rlfh_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output rlfh_pkg::rsp_t                           out_data
);
  import rlfh_pkg::*;

  localparam int TW = $clog2(NUM_TASKS);

  logic [LEVEL_W-1:0]   max_nesting;
  logic [TASK_W-1:0]    system_task;
  logic [LEVEL_W-1:0]   nest_level, nest_level_next;
  logic [TASK_W-1:0]    owner, owner_next;
  logic [NUM_TASKS-1:0] waiting, waiting_next;
  logic [ORDER_W-1:0]   next_order;
  req_t                 req;

  logic                 found;
  logic [TW-1:0]        best;
  logic [ORDER_W-1:0]   best_order;
  logic [TW-1:0]        rd_idx;
  logic [ORDER_W-1:0]   rd_order;

  logic is_sys, in_range, grant, need_scan;
  logic do_grant, do_queue, do_handoff;
  rsp_t rsp;

  rlfh_ram #(
    .WIDTH (ORDER_W),
    .DEPTH (NUM_TASKS)
  ) u_order_ram (
    .clk     (clk),
    .wr_en   (do_queue),
    .wr_addr (TW'(req.task_req)),
    .wr_data (next_order),
    .rd_addr (rd_addr),
    .rd_data (rd_order)
  );

  assign is_sys    = (req.task_req == system_task);
  assign in_range  = (int'(req.task_req) < NUM_TASKS);
  assign grant     = (nest_level == '0) ||
                     ((owner == req.task_req) && (nest_level < max_nesting));
  assign need_scan = (req.command == CMD_RELEASE) && (nest_level <= LEVEL_W'(1));

  assign do_grant   = cmd.commit && (req.command == CMD_TAKE) && !is_sys && grant;
  assign do_queue   = cmd.commit && (req.command == CMD_TAKE) && !is_sys && !grant &&
                      req.may_wait && in_range;
  assign do_handoff = cmd.commit && need_scan && found;

  assign sts.need_scan = need_scan;
  assign sts.slot_free = !out_valid || !out_stall;

  always_comb begin
    rsp             = '0;
    nest_level_next = nest_level;
    owner_next      = owner;
    if (req.command == CMD_TAKE) begin
      priority if (is_sys) begin
        rsp.status = ST_SYSTEM;
      end else if (grant) begin
        nest_level_next = nest_level + LEVEL_W'(1);
        owner_next      = req.task_req;
        rsp.status      = ST_GRANTED;
        rsp.level       = nest_level + LEVEL_W'(1);
      end else if (req.may_wait && in_range) begin
        rsp.status = ST_QUEUED;
      end else begin
        rsp.status = ST_BUSY;
      end
    end else if (!need_scan) begin
      nest_level_next = nest_level - LEVEL_W'(1);
      rsp.status      = ST_HELD;
      rsp.level       = nest_level - LEVEL_W'(1);
    end else begin
      if (found) begin
        nest_level_next = LEVEL_W'(1);
        owner_next      = TASK_W'(best);
        rsp.woken_valid = 1'b1;
        rsp.woken_task  = TASK_W'(best);
        rsp.status      = ST_HANDOFF;
      end else begin
        nest_level_next = '0;
        owner_next      = '0;
        rsp.status      = ST_FREED;
      end
      if (nest_level == '0) begin
        rsp.status = ST_RELERR;
      end
    end
  end

  always_comb begin
    waiting_next = waiting;
    for (int i = 0; i < NUM_TASKS; i++) begin
      if ((do_grant || do_queue) && (int'(req.task_req) == i)) begin
        waiting_next[i] = do_queue;
      end
      if (do_handoff && (int'(best) == i)) begin
        waiting_next[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_nesting <= MAX_NESTING_RESET;
      system_task <= SYSTEM_TASK_RESET;
    end else if (cfg_write) begin
      if (cfg_index == REG_MAX_NESTING) begin
        max_nesting <= cfg_data[LEVEL_W-1:0];
      end else if (cfg_index == REG_SYSTEM_TASK) begin
        system_task <= cfg_data[TASK_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nest_level <= '0;
      owner      <= '0;
      waiting    <= '0;
      next_order <= '0;
      out_valid  <= 1'b0;
      found      <= 1'b0;
    end else begin
      waiting <= waiting_next;
      if (cmd.commit) begin
        nest_level <= nest_level_next;
        owner      <= owner_next;
        out_valid  <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (do_queue) begin
        next_order <= next_order + ORDER_W'(1);
      end
      if (cmd.scan_clear) begin
        found <= 1'b0;
      end else if (cmd.cmp_en && waiting[rd_idx] && (!found || rd_order < best_order)) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= rd_addr;
    if (cmd.load) begin
      req <= in_data;
    end
    if (cmd.commit) begin
      out_data <= rsp;
    end
    if (cmd.cmp_en && waiting[rd_idx] && (!found || rd_order < best_order)) begin
      best       <= rd_idx;
      best_order <= rd_order;
    end
  end

endmodule

`default_nettype wire

### sv/recursive_lock_fifo_handoff_unit.sv
// Recursive lock with first-come handoff: top level joining sequencer and datapath.
// Depends on rlfh_pkg, rlfh_ctrl, rlfh_dp.
//
// Usage:
//   Requests enter on in_valid/in_stall with in_data (command, task_req, may_wait);
//   each beat yields exactly one result beat on out_valid/out_stall with out_data.
//   Registers are written through cfg_write/cfg_index/cfg_data while the unit is idle:
//   index 0 max_nesting, index 1 system_task.
//   Take requests and partial releases commit their result straight from the execute
//   state. Releases that free the lock first run the oldest-waiter scan through the
//   wait-order RAM at one slot per cycle, then commit.
//   One request is in work at a time; in_stall is high from the cycle after a request
//   beat until its result is committed to the output register, so the next request is
//   taken only after that commit.
//   A finished result waits in the output register while out_stall is high; the next
//   request is still taken, and its result is held back until the register drains.
//   Synchronous reset frees the lock, clears all waiters, the sequence counter and
//   out_valid, and restores max_nesting to 65535 and system_task to 0.
`default_nettype none

module recursive_lock_fifo_handoff_unit #(
  parameter int NUM_TASKS = rlfh_pkg::DEF_NUM_TASKS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire rlfh_pkg::req_t                  in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output rlfh_pkg::rsp_t                       out_data,
  input  wire logic                            cfg_write,
  input  wire logic [rlfh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rlfh_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rlfh_pkg::*;

  ctrl_cmd_t                    cmd;
  ctrl_sts_t                    sts;
  logic [$clog2(NUM_TASKS)-1:0] rd_addr;

  rlfh_ctrl #(
    .NUM_TASKS (NUM_TASKS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd),
    .rd_addr  (rd_addr)
  );

  rlfh_dp #(
    .NUM_TASKS (NUM_TASKS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .rd_addr   (rd_addr),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### sv/rlfh_assert.sv
// Port checker for the recursive lock handoff unit, bound to the top level.
// Depends on rlfh_pkg and recursive_lock_fifo_handoff_unit_defines.svh.
`default_nettype none
`include "recursive_lock_fifo_handoff_unit_defines.svh"

module rlfh_assert (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           in_valid,
  input wire logic           in_stall,
  input wire logic           out_valid,
  input wire logic           out_stall,
  input wire rlfh_pkg::rsp_t out_data
);
  import rlfh_pkg::*;

  // hold a stalled result beat
  `RLFH_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // one request in work at a time
  `RLFH_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall)

  // woken task reported only on a handoff or a release error
  `RLFH_ASSERT_NOW(a_woken_status, out_valid && out_data.woken_valid, out_data.status == ST_HANDOFF || out_data.status == ST_RELERR)

  // level carried only by a grant or partial release
  `RLFH_ASSERT_NOW(a_level_use, out_valid && out_data.status != ST_GRANTED && out_data.status != ST_HELD, out_data.level == '0)

endmodule

bind recursive_lock_fifo_handoff_unit rlfh_assert u_rlfh_assert (.*);

`default_nettype wire

### tb/tb_recursive_lock_fifo_handoff_unit.sv
// Testbench for the recursive lock handoff unit: drives take/release beats and checks
// every result beat against a cycle-free model of the lock held in this file.
// Depends on rlfh_pkg and recursive_lock_fifo_handoff_unit.
`timescale 1ns / 1ps

module tb_recursive_lock_fifo_handoff_unit;
  import rlfh_pkg::*;

  localparam int TASKS = 16;
  localparam int CLIMB = 40;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_data;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  recursive_lock_fifo_handoff_unit #(.NUM_TASKS(TASKS)) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // lock model state and its copy of the registers
  logic [LEVEL_W-1:0] nest_limit = MAX_NESTING_RESET;
  logic [TASK_W-1:0] sys_task = SYSTEM_TASK_RESET;
  logic [LEVEL_W-1:0] held_level = '0;
  logic [TASK_W-1:0] holder = '0;
  logic waiting [TASKS];
  logic [ORDER_W-1:0] ticket [TASKS];
  logic [ORDER_W-1:0] next_ticket = '0;

  req_t requests_to_send [$];
  rsp_t expected_results [$];

  bit idle_on = 1'b0;
  bit hold_arm = 1'b0;
  bit hold_started = 1'b0;
  int unsigned hold_left = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned fail_count = 0;
  int unsigned pool_base = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    for (int i = 0; i < TASKS; i++) waiting[i] = 1'b0;
  end

  function automatic rsp_t next_lock_result(req_t r);
    rsp_t res;
    int oldest;
    res = '0;
    oldest = -1;
    if (r.command == CMD_TAKE) begin
      if (r.task_req == sys_task) begin
        res.status = ST_SYSTEM;
      end else if (held_level == 0 || (holder == r.task_req && held_level < nest_limit)) begin
        held_level = held_level + 1'b1;
        holder = r.task_req;
        waiting[r.task_req] = 1'b0;
        res.status = ST_GRANTED;
        res.level = held_level;
      end else if (!r.may_wait) begin
        res.status = ST_BUSY;
      end else begin
        waiting[r.task_req] = 1'b1;
        ticket[r.task_req] = next_ticket;
        next_ticket = next_ticket + 1'b1;
        res.status = ST_QUEUED;
      end
    end else if (held_level > 1) begin
      held_level = held_level - 1'b1;
      res.status = ST_HELD;
      res.level = held_level;
    end else begin
      for (int i = 0; i < TASKS; i++) begin
        if (waiting[i] && (oldest < 0 || ticket[i] < ticket[oldest])) oldest = i;
      end
      res.status = (held_level == 0) ? ST_RELERR : ST_FREED;
      held_level = '0;
      holder = '0;
      if (oldest >= 0) begin
        waiting[oldest] = 1'b0;
        held_level = 16'd1;
        holder = TASK_W'(oldest);
        res.woken_valid = 1'b1;
        res.woken_task = TASK_W'(oldest);
        if (res.status == ST_FREED) res.status = ST_HANDOFF;
      end
    end
    return res;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!idle_on || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void note_fail(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  function automatic void push_req(logic cmd, int unsigned tsk, logic may_wait);
    req_t r;
    r.command = cmd;
    r.task_req = TASK_W'(tsk);
    r.may_wait = may_wait;
    requests_to_send.push_back(r);
  endfunction

  function automatic req_t random_req();
    req_t r;
    r.command = ($urandom_range(0, 99) < 45) ? CMD_RELEASE : CMD_TAKE;
    if ($urandom_range(0, 3) == 0) r.task_req = TASK_W'($urandom_range(0, TASKS - 1));
    else r.task_req = TASK_W'(pool_base + $urandom_range(0, 3));
    r.may_wait = ($urandom_range(0, 9) < 7);
    return r;
  endfunction

  // request beats
  always @(posedge clk) begin : drive
    rsp_t predicted;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (in_valid && !in_stall) begin
      predicted = next_lock_result(in_data);
      expected_results.push_back(predicted);
      gap_left <= pick_gap();
      if (requests_to_send.size() != 0 && (!idle_on || $urandom_range(0, 1) == 0)) begin
        in_data <= requests_to_send.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end else if (!in_valid) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
      end else if (requests_to_send.size() != 0) begin
        in_valid <= 1'b1;
        in_data <= requests_to_send.pop_front();
      end
    end
  end

  // long receiver hold-off, so the unit fills and stalls its input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_arm && !hold_started) begin
      hold_left <= 250;
      hold_started <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result beats
  always @(posedge clk) begin : watch
    rsp_t want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          note_fail($sformatf("unexpected result beat: status %0d level %0d woken %0b/%0d",
                              out_data.status, out_data.level, out_data.woken_valid,
                              out_data.woken_task));
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status || out_data.level !== want.level ||
              out_data.woken_valid !== want.woken_valid ||
              out_data.woken_task !== want.woken_task) begin
            note_fail($sformatf({"mismatch: expected status %0d level %0d woken %0b/%0d,",
                                 " got status %0d level %0d woken %0b/%0d"},
                                want.status, want.level, want.woken_valid, want.woken_task,
                                out_data.status, out_data.level, out_data.woken_valid,
                                out_data.woken_task));
          end
        end
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
      end else if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        stall_left <= pick_gap();
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic drain();
    do @(negedge clk);
    while (requests_to_send.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_MAX_NESTING) nest_limit = val;
    else sys_task = val[TASK_W-1:0];
    @(negedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: system task refused, release while free, queueing and handoff
    idle_on = 1'b1;
    push_req(CMD_TAKE, 0, 1'b1);
    push_req(CMD_RELEASE, 4, 1'b0);
    push_req(CMD_TAKE, 5, 1'b0);
    push_req(CMD_TAKE, 5, 1'b1);
    push_req(CMD_TAKE, 3, 1'b0);
    push_req(CMD_TAKE, 3, 1'b1);
    push_req(CMD_TAKE, 15, 1'b1);
    push_req(CMD_TAKE, 3, 1'b1);
    push_req(CMD_RELEASE, 9, 1'b1);
    push_req(CMD_RELEASE, 5, 1'b0);
    push_req(CMD_TAKE, 15, 1'b1);
    push_req(CMD_TAKE, 0, 1'b0);
    push_req(CMD_RELEASE, 15, 1'b0);
    push_req(CMD_RELEASE, 15, 1'b0);
    push_req(CMD_RELEASE, 3, 1'b0);
    push_req(CMD_RELEASE, 3, 1'b1);
    drain();

    // non-recursive lock; the owner queues behind itself
    write_reg(REG_MAX_NESTING, '0);
    write_reg(REG_SYSTEM_TASK, CFG_DATA_W'(15));
    push_req(CMD_TAKE, 15, 1'b0);
    push_req(CMD_TAKE, 2, 1'b0);
    push_req(CMD_TAKE, 2, 1'b1);
    push_req(CMD_TAKE, 7, 1'b1);
    drain();
    // raise the limit while held: the waiting owner is granted again
    write_reg(REG_MAX_NESTING, CFG_DATA_W'(3));
    push_req(CMD_TAKE, 2, 1'b0);
    push_req(CMD_TAKE, 2, 1'b1);
    push_req(CMD_TAKE, 2, 1'b0);
    push_req(CMD_RELEASE, 2, 1'b0);
    push_req(CMD_RELEASE, 2, 1'b0);
    push_req(CMD_RELEASE, 2, 1'b0);
    push_req(CMD_RELEASE, 7, 1'b0);
    push_req(CMD_TAKE, 0, 1'b0);
    push_req(CMD_RELEASE, 0, 1'b0);
    drain();

    // climb to the limit and back, no idling
    idle_on = 1'b0;
    write_reg(REG_MAX_NESTING, CFG_DATA_W'(CLIMB));
    write_reg(REG_SYSTEM_TASK, CFG_DATA_W'(9));
    for (int n = 0; n < CLIMB; n++) push_req(CMD_TAKE, 1, n[0]);
    push_req(CMD_TAKE, 1, 1'b0);
    push_req(CMD_TAKE, 1, 1'b1);
    for (int n = 0; n < CLIMB + 1; n++) push_req(CMD_RELEASE, 1, n[1]);
    drain();

    // random traffic under several settings
    for (int ph = 0; ph < 5; ph++) begin
      idle_on = (ph != 2);
      pool_base = $urandom_range(0, TASKS - 4);
      case (ph)
        0: write_reg(REG_MAX_NESTING, CFG_DATA_W'($urandom_range(1, 4)));
        1: write_reg(REG_MAX_NESTING, MAX_NESTING_RESET);
        2: write_reg(REG_MAX_NESTING, '0);
        3: write_reg(REG_MAX_NESTING, CFG_DATA_W'($urandom_range(2, 6)));
        default: write_reg(REG_MAX_NESTING, CFG_DATA_W'($urandom_range(0, 65535)));
      endcase
      write_reg(REG_SYSTEM_TASK, CFG_DATA_W'($urandom_range(0, TASKS - 1)));
      for (int n = 0; n < 260; n++) requests_to_send.push_back(random_req());
      if (ph == 1) hold_arm = 1'b1;
      drain();
    end

    repeat (40) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
